/* rtl/efpa_pkg.sv */
// Shared constants and types for the encoder frame parser.
`default_nettype none
package efpa_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int DIV_W   = 17;
	localparam int ANGLE_W = 25;
	localparam int POS_W   = 4;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'h04;
	localparam logic [DIV_W-1:0]  MAX_STEP_RST = 17'd4096;

	// byte positions within the reply; POS_IDLE waits for a frame start
	localparam logic [POS_W-1:0] POS_START   = 4'd0;
	localparam logic [POS_W-1:0] POS_HEADER  = 4'd1;
	localparam logic [POS_W-1:0] POS_REV_HI  = 4'd2;
	localparam logic [POS_W-1:0] POS_REV_LO  = 4'd3;
	localparam logic [POS_W-1:0] POS_STEP_HI = 4'd4;
	localparam logic [POS_W-1:0] POS_STEP_LO = 4'd5;
	localparam logic [POS_W-1:0] POS_CHECK   = 4'd6;
	localparam logic [POS_W-1:0] POS_END     = 4'd7;
	localparam logic [POS_W-1:0] POS_IDLE    = 4'd8;

	typedef struct packed {
		logic [WORD_W-1:0] revolution;
		logic [WORD_W-1:0] step;
	} frame_t;

	typedef struct packed {
		logic busy;
		logic valid;
	} div_stat_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage
`default_nettype wire

/* rtl/efpa_parser.sv */
// Byte parser: tracks frame position, running XOR and delimiter checks.
`default_nettype none
module efpa_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [efpa_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        frame_first,
	output efpa_pkg::frame_t                 frame,
	output logic                             frame_ok
);
	import efpa_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos;
	logic              start_ok_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] chk_q;
	logic [WORD_W-1:0] rev_q;
	logic [WORD_W-1:0] step_q;

	assign pos = frame_first ? POS_START : pos_q;

	assign frame_ok = accept && (pos == POS_END) && start_ok_q &&
		(rx_byte == END_BYTE) && (xor_q == chk_q);

	assign frame.revolution = rev_q;
	assign frame.step       = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_IDLE;
			start_ok_q <= 1'b0;
		end else if (accept && (pos < POS_IDLE)) begin
			if (pos == POS_START)
				start_ok_q <= (rx_byte == START_BYTE);
			pos_q <= (pos == POS_END) ? POS_IDLE : pos + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos < POS_IDLE)) begin
			unique case (pos)
				POS_START: xor_q <= '0;
				POS_HEADER: xor_q <= xor_q ^ rx_byte;
				POS_REV_HI: begin
					xor_q       <= xor_q ^ rx_byte;
					rev_q[15:8] <= rx_byte;
				end
				POS_REV_LO: begin
					xor_q      <= xor_q ^ rx_byte;
					rev_q[7:0] <= rx_byte;
				end
				POS_STEP_HI: begin
					xor_q        <= xor_q ^ rx_byte;
					step_q[15:8] <= rx_byte;
				end
				POS_STEP_LO: begin
					xor_q       <= xor_q ^ rx_byte;
					step_q[7:0] <= rx_byte;
				end
				POS_CHECK: chk_q <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/efpa_div.sv */
// Bit-serial restoring divider for the angle scaling, with saturation.
`default_nettype none
module efpa_div #(
	parameter int FRAC = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [efpa_pkg::WORD_W-1:0]  step,
	input  wire logic [efpa_pkg::DIV_W-1:0]   divisor,
	input  wire logic                         res_take,
	output efpa_pkg::div_stat_t               stat,
	output logic [efpa_pkg::ANGLE_W-1:0]      quot
);
	import efpa_pkg::*;

	localparam int NUM_W = ANGLE_W + FRAC;
	localparam int CMP_W = (FRAC > DIV_W) ? FRAC : DIV_W;
	localparam int CNT_W = $clog2(ANGLE_W);

	div_state_t state_q, state_d;

	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_q;
	logic [ANGLE_W-1:0] sh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [ANGLE_W-1:0] prod;
	logic [NUM_W-1:0]   num;
	logic [FRAC-1:0]    rem0;
	logic               sat;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     diff;
	logic               ge;

	// 360 * step as shifted adds: 256 + 64 + 32 + 8
	assign prod = (ANGLE_W'(step) << 8) + (ANGLE_W'(step) << 6) +
		(ANGLE_W'(step) << 5) + (ANGLE_W'(step) << 3);
	assign num  = {prod, {FRAC{1'b0}}};
	// leading part of the dividend; quotient overflows 25 bits iff it reaches the divisor
	assign rem0 = num[NUM_W-1 -: FRAC];
	assign sat  = (divisor == '0) || (CMP_W'(rem0) >= CMP_W'(divisor));

	assign trial = {rem_q, sh_q[ANGLE_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign quot = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= DIV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		stat.busy  = 1'b1;
		stat.valid = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				stat.busy = 1'b0;
				if (start)
					state_d = sat ? DIV_DONE : DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == CNT_W'(ANGLE_W - 1))
					state_d = DIV_DONE;
			end
			DIV_DONE: begin
				stat.valid = 1'b1;
				if (res_take)
					state_d = DIV_IDLE;
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == DIV_IDLE) && start) begin
			div_q <= divisor;
			cnt_q <= '0;
			if (sat) begin
				sh_q <= '1;
			end else begin
				rem_q <= DIV_W'(rem0);
				sh_q  <= num[ANGLE_W-1:0];
			end
		end else if (state_q == DIV_RUN) begin
			sh_q  <= {sh_q[ANGLE_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/encoder_frame_parser_angle.sv */
// Top level: encoder reply parser with serial angle scaling and output register.
//
//  port group  direction  handshake            payload
//  in          input      in_valid / in_stall  rx_byte, frame_first
//  out         output     out_valid / out_stall revolution, step_raw, angle_q16
//  cfg         input      cfg_valid / cfg_ready cfg_max_step
//
// A byte is taken while in_valid is high and in_stall is low. A good end byte
// starts the divider, which produces one quotient bit per cycle; the result
// then waits until the output register takes it (a saturated result skips the
// bit loop). in_stall is high while the divider runs or holds a result.
// The output register holds a word under out_stall while new bytes are accepted.
// Reset (arst_n low) idles the parser and sets max_step to 4096.
`default_nettype none
module encoder_frame_parser_angle #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [efpa_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                         frame_first,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [efpa_pkg::WORD_W-1:0]       revolution,
	output logic [efpa_pkg::WORD_W-1:0]       step_raw,
	output logic [efpa_pkg::ANGLE_W-1:0]      angle_q16,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [efpa_pkg::DIV_W-1:0]   cfg_max_step
);
	import efpa_pkg::*;

	logic               in_accept;
	logic               frame_ok;
	frame_t             frame;
	div_stat_t          dstat;
	logic [ANGLE_W-1:0] quot;
	logic               res_take;
	logic [DIV_W-1:0]   max_step_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  rev_q;
	logic [WORD_W-1:0]  step_q;
	logic [ANGLE_W-1:0] angle_q;

	assign in_stall  = dstat.busy;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign res_take  = dstat.valid && (!out_valid_q || !out_stall);

	efpa_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.rx_byte     (rx_byte),
		.frame_first (frame_first),
		.frame       (frame),
		.frame_ok    (frame_ok)
	);

	efpa_div #(
		.FRAC (ANGLE_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (frame_ok),
		.step     (frame.step),
		.divisor  (max_step_q),
		.res_take (res_take),
		.stat     (dstat),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q  <= MAX_STEP_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_step_q <= cfg_max_step;
			if (res_take)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// frame holds stay put while the divider runs: no byte is taken then
	always_ff @(posedge clk) begin
		if (res_take) begin
			rev_q   <= frame.revolution;
			step_q  <= frame.step;
			angle_q <= quot;
		end
	end

	assign out_valid  = out_valid_q;
	assign revolution = rev_q;
	assign step_raw   = step_q;
	assign angle_q16  = angle_q;

endmodule
`default_nettype wire
